// ===== rtl/yge_pkg.sv =====
// Shared constants, codes and control/status types for the Yee-grid energy accumulator.
package yge_pkg;

  // Grid and material sizing
  localparam int unsigned GridMax       = 1024;
  localparam int unsigned MaterialCount = 256;
  localparam int unsigned NumComp       = 6;
  localparam int unsigned CellW         = 11;
  localparam int unsigned CoefDepth     = NumComp * MaterialCount;
  localparam int unsigned CoefAw        = $clog2(CoefDepth);
  localparam int unsigned ApbAw         = 4;

  // Commands
  localparam logic [3:0] CmdSampleEx = 4'd0;
  localparam logic [3:0] CmdSampleEy = 4'd1;
  localparam logic [3:0] CmdSampleEz = 4'd2;
  localparam logic [3:0] CmdSampleBx = 4'd3;
  localparam logic [3:0] CmdSampleBy = 4'd4;
  localparam logic [3:0] CmdSampleBz = 4'd5;
  localparam logic [3:0] CmdCoefEx   = 4'd6;
  localparam logic [3:0] CmdCoefBz   = 4'd11;
  localparam logic [3:0] CmdEmit     = 4'd12;

  // Component indexes
  localparam logic [2:0] CompEx = 3'd0;
  localparam logic [2:0] CompEy = 3'd1;
  localparam logic [2:0] CompEz = 3'd2;
  localparam logic [2:0] CompBx = 3'd3;
  localparam logic [2:0] CompBy = 3'd4;
  localparam logic [2:0] CompBz = 3'd5;

  // Register indexes
  localparam logic [1:0] RegCellsX       = 2'd0;
  localparam logic [1:0] RegCellsY       = 2'd1;
  localparam logic [1:0] RegCellsZ       = 2'd2;
  localparam logic [1:0] RegEnergyScale  = 2'd3;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MulSq,
    MulSampleHi,
    MulSampleLo,
    MulSumHi,
    MulSumLo
  } mul_sel_e;

  typedef struct packed {
    logic     capture;
    mul_sel_e mul_sel;
    logic     load_sq;
    logic     load_hi;
    logic     load_contrib;
    logic     acc;
    logic     emit_write;
    logic     comp_inc;
  } yge_cmd_t;

  typedef struct packed {
    logic sample_go;
    logic emit;
    logic last_comp;
  } yge_status_t;

endpackage

// ===== rtl/yge_regs.sv =====
// APB-style configuration registers: cell counts and energy scale.
module yge_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [yge_pkg::ApbAw-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [yge_pkg::CellW-1:0]   cells_x_o,
  output logic [yge_pkg::CellW-1:0]   cells_y_o,
  output logic [yge_pkg::CellW-1:0]   cells_z_o,
  output logic [31:0]                 energy_scale_o
);

  logic [yge_pkg::CellW-1:0] cells_x_q, cells_y_q, cells_z_q, cells_wr;
  logic [31:0]               scale_q;
  logic                      wr_en;
  logic [1:0]                reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // counts above the grid limit saturate
  assign cells_wr = (pwdata[yge_pkg::CellW-1:0] > yge_pkg::CellW'(yge_pkg::GridMax)) ?
                    yge_pkg::CellW'(yge_pkg::GridMax) : pwdata[yge_pkg::CellW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= yge_pkg::CellW'(1);
      cells_y_q <= yge_pkg::CellW'(1);
      cells_z_q <= yge_pkg::CellW'(1);
      scale_q   <= 32'h0001_0000;
    end else if (wr_en) begin
      unique case (reg_idx)
        yge_pkg::RegCellsX:      cells_x_q <= cells_wr;
        yge_pkg::RegCellsY:      cells_y_q <= cells_wr;
        yge_pkg::RegCellsZ:      cells_z_q <= cells_wr;
        yge_pkg::RegEnergyScale: scale_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      yge_pkg::RegCellsX:      prdata = 32'(cells_x_q);
      yge_pkg::RegCellsY:      prdata = 32'(cells_y_q);
      yge_pkg::RegCellsZ:      prdata = 32'(cells_z_q);
      yge_pkg::RegEnergyScale: prdata = scale_q;
      default:                 prdata = '0;
    endcase
  end

  assign cells_x_o      = cells_x_q;
  assign cells_y_o      = cells_y_q;
  assign cells_z_o      = cells_z_q;
  assign energy_scale_o = scale_q;

endmodule

// ===== rtl/yge_ctrl.sv =====
// Sequencer for sample accumulate and emit passes; owns the result valid.
module yge_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  yge_pkg::yge_status_t status_i,
  output yge_pkg::yge_cmd_t    cmd_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SSq    = 4'd1;
  localparam logic [3:0] SHi    = 4'd2;
  localparam logic [3:0] SLo    = 4'd3;
  localparam logic [3:0] SCon   = 4'd4;
  localparam logic [3:0] SAcc   = 4'd5;
  localparam logic [3:0] SEWait = 4'd6;
  localparam logic [3:0] SEHi   = 4'd7;
  localparam logic [3:0] SELo   = 4'd8;
  localparam logic [3:0] SEWr   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == SIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_sel = yge_pkg::MulSq;
    unique case (state_q)
      SIdle: begin
        cmd_o.capture = accept;
        if (accept && status_i.sample_go) begin
          state_d = SSq;
        end else if (accept && status_i.emit) begin
          state_d = SEWait;
        end
      end
      SSq: begin
        cmd_o.mul_sel = yge_pkg::MulSq;
        state_d = SHi;
      end
      SHi: begin
        cmd_o.mul_sel = yge_pkg::MulSampleHi;
        cmd_o.load_sq = 1'b1;
        state_d = SLo;
      end
      SLo: begin
        cmd_o.mul_sel = yge_pkg::MulSampleLo;
        cmd_o.load_hi = 1'b1;
        state_d = SCon;
      end
      SCon: begin
        cmd_o.load_contrib = 1'b1;
        state_d = SAcc;
      end
      SAcc: begin
        cmd_o.acc = 1'b1;
        state_d = SIdle;
      end
      SEWait: begin
        if (!out_valid_q) begin
          state_d = SEHi;
        end
      end
      SEHi: begin
        cmd_o.mul_sel = yge_pkg::MulSumHi;
        state_d = SELo;
      end
      SELo: begin
        cmd_o.mul_sel = yge_pkg::MulSumLo;
        cmd_o.load_hi = 1'b1;
        state_d = SEWr;
      end
      SEWr: begin
        cmd_o.emit_write = 1'b1;
        if (status_i.last_comp) begin
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end else begin
          cmd_o.comp_inc = 1'b1;
          state_d        = SEHi;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output registers are only rewritten while empty
  a_emit_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEHi || state_q == SELo || state_q == SEWr) |-> !out_valid_q)
    else $error("emit pass running while result still pending");

  a_emit_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.emit) |=> (state_q == SEWait))
    else $error("accepted emit did not start an emit pass");

  a_sample_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.sample_go) |=> (state_q == SSq))
    else $error("accepted sample did not start accumulation");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == SEWr && status_i.last_comp))
    else $error("result valid raised outside the last emit write");

endmodule

// ===== rtl/yge_dp.sv =====
// Datapath: stencil weight, coefficient memory, shared multiplier, sums and result registers.
module yge_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [3:0]                  cmd_i,
  input  logic signed [31:0]          value_i,
  input  logic [7:0]                  material_i,
  input  logic [yge_pkg::CellW-1:0]   pos_x_i,
  input  logic [yge_pkg::CellW-1:0]   pos_y_i,
  input  logic [yge_pkg::CellW-1:0]   pos_z_i,
  input  logic [yge_pkg::CellW-1:0]   cells_x_i,
  input  logic [yge_pkg::CellW-1:0]   cells_y_i,
  input  logic [yge_pkg::CellW-1:0]   cells_z_i,
  input  logic [31:0]                 energy_scale_i,
  input  yge_pkg::yge_cmd_t           cmd_ctl_i,
  output yge_pkg::yge_status_t        status_o,
  output logic [63:0]                 energy_ex_o,
  output logic [63:0]                 energy_ey_o,
  output logic [63:0]                 energy_ez_o,
  output logic [63:0]                 energy_bx_o,
  output logic [63:0]                 energy_by_o,
  output logic [63:0]                 energy_bz_o
);

  function automatic logic in_range(input logic [yge_pkg::CellW-1:0] p,
                                    input logic [yge_pkg::CellW-1:0] n);
    in_range = (p != '0) && (p <= n);
  endfunction

  // voxel p and voxel p-1 both may use the sample
  function automatic logic [1:0] spread_cnt(input logic [yge_pkg::CellW-1:0] p,
                                            input logic [yge_pkg::CellW-1:0] n);
    logic lo_hit;
    lo_hit = (p > yge_pkg::CellW'(1)) &&
             ({1'b0, p} <= ({1'b0, n} + (yge_pkg::CellW+1)'(1)));
    spread_cnt = {1'b0, in_range(p, n)} + {1'b0, lo_hit};
  endfunction

  logic                      in_x, in_y, in_z;
  logic [1:0]                sp_x, sp_y, sp_z;
  logic [2:0]                q_d, q_q;
  logic                      is_sample, is_coef, mat_ok;
  logic [2:0]                coef_comp;
  logic [yge_pkg::CoefAw-1:0] raddr, waddr;
  logic [31:0]               mag_d, mag_q;
  logic [31:0]               coef_mem [yge_pkg::CoefDepth];
  logic [31:0]               coef_q;
  logic [2:0]                comp_q;
  logic [31:0]               op_a, op_b;
  logic [63:0]               prod_q, hi_q, contrib_q, contrib_d;
  logic [31:0]               sq_q;
  logic [95:0]               full_prod;
  logic [64:0]               acc_sum, scale_sum;
  logic [63:0]               acc_val, scaled;
  logic [63:0]               sums_q [yge_pkg::NumComp];
  logic [63:0]               energy_q [yge_pkg::NumComp];

  // stencil weight in quarters
  assign in_x = in_range(pos_x_i, cells_x_i);
  assign in_y = in_range(pos_y_i, cells_y_i);
  assign in_z = in_range(pos_z_i, cells_z_i);
  assign sp_x = spread_cnt(pos_x_i, cells_x_i);
  assign sp_y = spread_cnt(pos_y_i, cells_y_i);
  assign sp_z = spread_cnt(pos_z_i, cells_z_i);

  always_comb begin
    q_d = '0;
    case (cmd_i)
      yge_pkg::CmdSampleEx: q_d = in_x ? 3'({1'b0, sp_y}) * 3'({1'b0, sp_z}) : 3'd0;
      yge_pkg::CmdSampleEy: q_d = in_y ? 3'({1'b0, sp_z}) * 3'({1'b0, sp_x}) : 3'd0;
      yge_pkg::CmdSampleEz: q_d = in_z ? 3'({1'b0, sp_x}) * 3'({1'b0, sp_y}) : 3'd0;
      yge_pkg::CmdSampleBx: q_d = (in_y && in_z) ? {sp_x, 1'b0} : 3'd0;
      yge_pkg::CmdSampleBy: q_d = (in_z && in_x) ? {sp_y, 1'b0} : 3'd0;
      yge_pkg::CmdSampleBz: q_d = (in_x && in_y) ? {sp_z, 1'b0} : 3'd0;
      default:              q_d = 3'd0;
    endcase
  end

  assign mat_ok    = ({1'b0, material_i} < 9'(yge_pkg::MaterialCount));
  assign is_sample = (cmd_i <= yge_pkg::CmdSampleBz);
  assign is_coef   = (cmd_i >= yge_pkg::CmdCoefEx) && (cmd_i <= yge_pkg::CmdCoefBz);
  assign coef_comp = 3'(cmd_i - yge_pkg::CmdCoefEx);

  assign status_o.sample_go = is_sample && mat_ok && (q_d != 3'd0);
  assign status_o.emit      = (cmd_i == yge_pkg::CmdEmit);
  assign status_o.last_comp = (comp_q == yge_pkg::CompBz);

  // |value|; the most negative value maps to 2^31
  assign mag_d = value_i[31] ? (~value_i + 32'd1) : value_i;

  assign raddr = yge_pkg::CoefAw'(cmd_i[2:0]) * yge_pkg::CoefAw'(yge_pkg::MaterialCount) +
                 yge_pkg::CoefAw'(material_i);
  assign waddr = yge_pkg::CoefAw'(coef_comp) * yge_pkg::CoefAw'(yge_pkg::MaterialCount) +
                 yge_pkg::CoefAw'(material_i);

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.capture && is_coef && mat_ok) begin
      coef_mem[waddr] <= value_i;
    end
    if (cmd_ctl_i.capture) begin
      coef_q <= coef_mem[raddr];
    end
  end

  // shared 32x32 multiplier, registered product
  always_comb begin
    case (cmd_ctl_i.mul_sel)
      yge_pkg::MulSq:       begin op_a = mag_q;          op_b = mag_q;          end
      yge_pkg::MulSampleHi: begin op_a = prod_q[63:32];  op_b = coef_q;         end
      yge_pkg::MulSampleLo: begin op_a = sq_q;           op_b = coef_q;         end
      yge_pkg::MulSumHi:    begin op_a = sums_q[comp_q][63:32]; op_b = energy_scale_i; end
      yge_pkg::MulSumLo:    begin op_a = sums_q[comp_q][31:0];  op_b = energy_scale_i; end
      default:              begin op_a = '0;             op_b = '0;             end
    endcase
  end

  // coef*sq*q / 2^34; q is 1, 2 or 4
  assign full_prod = {hi_q, 32'd0} + {32'd0, prod_q};
  always_comb begin
    case (q_q)
      3'd1:    contrib_d = 64'(full_prod >> 34);
      3'd2:    contrib_d = 64'(full_prod >> 33);
      3'd4:    contrib_d = 64'(full_prod >> 32);
      default: contrib_d = '0;
    endcase
  end

  assign acc_sum = {1'b0, sums_q[comp_q]} + {1'b0, contrib_q};
  assign acc_val = acc_sum[64] ? '1 : acc_sum[63:0];

  // sum*scale / 2^16 with saturation; hi_q holds the upper partial product
  assign scale_sum = {1'b0, hi_q[47:0], 16'd0} + {17'd0, prod_q[63:16]};
  assign scaled    = ((hi_q[63:48] != '0) || scale_sum[64]) ? '1 : scale_sum[63:0];

  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, op_a} * {32'd0, op_b};
    if (cmd_ctl_i.capture) begin
      mag_q <= mag_d;
      q_q   <= q_d;
    end
    if (cmd_ctl_i.load_sq) begin
      sq_q <= prod_q[31:0];
    end
    if (cmd_ctl_i.load_hi) begin
      hi_q <= prod_q;
    end
    if (cmd_ctl_i.load_contrib) begin
      contrib_q <= contrib_d;
    end
    if (cmd_ctl_i.emit_write) begin
      energy_q[comp_q] <= scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= yge_pkg::CompEx;
      for (int i = 0; i < yge_pkg::NumComp; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      if (cmd_ctl_i.capture) begin
        comp_q <= is_sample ? cmd_i[2:0] : yge_pkg::CompEx;
      end else if (cmd_ctl_i.comp_inc) begin
        comp_q <= comp_q + 3'd1;
      end
      if (cmd_ctl_i.acc) begin
        sums_q[comp_q] <= acc_val;
      end else if (cmd_ctl_i.emit_write) begin
        sums_q[comp_q] <= '0;
      end
    end
  end

  assign energy_ex_o = energy_q[yge_pkg::CompEx];
  assign energy_ey_o = energy_q[yge_pkg::CompEy];
  assign energy_ez_o = energy_q[yge_pkg::CompEz];
  assign energy_bx_o = energy_q[yge_pkg::CompBx];
  assign energy_by_o = energy_q[yge_pkg::CompBy];
  assign energy_bz_o = energy_q[yge_pkg::CompBz];

endmodule

// ===== rtl/yee_grid_field_energy_accumulator_unit.sv =====
// Top level of the Yee-grid field energy accumulator.
// Accumulates coef*value^2*stencil-weight into six saturating Q48.16 energy
// sums (ex, ey, ez, bx, by, bz) over a staggered 3-D grid. Commands 0-5 add a
// sample, 6-11 write a per-material coefficient (no result), 12 emits the six
// sums scaled by energy_scale and clears them; 13-15 are no-ops. All work
// shares one registered 32x32 multiplier, so requests are taken one at a time:
// a coefficient write or no-op is done once accepted; a sample that lands in
// the stencil steps through square, two coefficient partial products, weight
// shift and saturating add; an emit first waits until the output register is
// free (the previous result taken), then scales each component's sum in a
// high and a low partial product and writes it.
// The result sits in an output register, so new requests are accepted while it
// waits. Samples outside the interior stencil or with zero weight are done once
// accepted. The coefficient memory (6 x 256 x 32) has no reset; every entry must
// be written before a sample reads it. Configuration (APB, 4-byte stride:
// cells_x, cells_y, cells_z, energy_scale) may only change while the block is
// idle; cell counts use the low 11 bits, and above 1024 are stored as 1024.
module yee_grid_field_energy_accumulator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [3:0]                cmd_i,
  input  logic signed [31:0]        value_i,
  input  logic [7:0]                material_i,
  input  logic [yge_pkg::CellW-1:0] pos_x_i,
  input  logic [yge_pkg::CellW-1:0] pos_y_i,
  input  logic [yge_pkg::CellW-1:0] pos_z_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [63:0]               energy_ex_o,
  output logic [63:0]               energy_ey_o,
  output logic [63:0]               energy_ez_o,
  output logic [63:0]               energy_bx_o,
  output logic [63:0]               energy_by_o,
  output logic [63:0]               energy_bz_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [yge_pkg::ApbAw-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [yge_pkg::CellW-1:0] cells_x, cells_y, cells_z;
  logic [31:0]               energy_scale;
  yge_pkg::yge_cmd_t         ctl_cmd;
  yge_pkg::yge_status_t      dp_status;

  yge_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cells_x_o      (cells_x),
    .cells_y_o      (cells_y),
    .cells_z_o      (cells_z),
    .energy_scale_o (energy_scale)
  );

  // sequencer: handshakes and pass control
  yge_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (ctl_cmd)
  );

  // datapath: weights, coefficient memory, multiplier, sums, result registers
  yge_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .material_i     (material_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .cells_x_i      (cells_x),
    .cells_y_i      (cells_y),
    .cells_z_i      (cells_z),
    .energy_scale_i (energy_scale),
    .cmd_ctl_i      (ctl_cmd),
    .status_o       (dp_status),
    .energy_ex_o    (energy_ex_o),
    .energy_ey_o    (energy_ey_o),
    .energy_ez_o    (energy_ez_o),
    .energy_bx_o    (energy_bx_o),
    .energy_by_o    (energy_by_o),
    .energy_bz_o    (energy_bz_o)
  );

endmodule

// ===== dv/yge_energy_checker.sv =====
// Checker for the Yee-grid energy accumulator: predicts emitted totals and compares results.
module yge_energy_checker
  import yge_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [3:0]         cmd_i,
  input  logic [31:0]        value_i,
  input  logic [7:0]         material_i,
  input  logic [CellW-1:0]   pos_x_i,
  input  logic [CellW-1:0]   pos_y_i,
  input  logic [CellW-1:0]   pos_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [63:0]        energy_ex_i,
  input  logic [63:0]        energy_ey_i,
  input  logic [63:0]        energy_ez_i,
  input  logic [63:0]        energy_bx_i,
  input  logic [63:0]        energy_by_i,
  input  logic [63:0]        energy_bz_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [ApbAw-1:0]   paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 mismatch_count_o,
  output int                 outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // index 0 = ex ... 5 = bz
  typedef logic [NumComp-1:0][63:0] energy_set_t;

  logic [31:0]      coef_mem [CoefDepth];
  logic [63:0]      energy_sums [NumComp];
  logic [CellW-1:0] grid_cells [3];
  logic [31:0]      scale_q16;
  energy_set_t      expected_totals [$];
  int               mismatches = 0;
  string            comp_name [NumComp] = '{"ex", "ey", "ez", "bx", "by", "bz"};

  assign mismatch_count_o = mismatches;

  function automatic logic [CellW-1:0] clamp_cells(input logic [31:0] v);
    return (v[CellW-1:0] > GridMax) ? CellW'(GridMax) : v[CellW-1:0];
  endfunction

  // 1 when p is an interior voxel along an axis of n cells
  function automatic logic [1:0] in_span(input logic [CellW-1:0] p, input logic [CellW-1:0] n);
    return (p >= 1 && p <= n) ? 2'd1 : 2'd0;
  endfunction

  // voxels p and p-1 both use a sample along a spreading axis
  function automatic logic [1:0] across(input logic [CellW-1:0] p, input logic [CellW-1:0] n);
    return in_span(p, n) + ((p >= 1) ? in_span(p - 1'b1, n) : 2'd0);
  endfunction

  // stencil weight in quarters: hits for E, 2*hits for B
  function automatic logic [3:0] stencil_quarters(input logic [3:0] c,
                                                  input logic [CellW-1:0] x,
                                                  input logic [CellW-1:0] y,
                                                  input logic [CellW-1:0] z);
    logic [3:0] hits;
    case (c)
      CmdSampleEx: hits = in_span(x, grid_cells[0]) * across(y, grid_cells[1])
                          * across(z, grid_cells[2]);
      CmdSampleEy: hits = across(x, grid_cells[0]) * in_span(y, grid_cells[1])
                          * across(z, grid_cells[2]);
      CmdSampleEz: hits = across(x, grid_cells[0]) * across(y, grid_cells[1])
                          * in_span(z, grid_cells[2]);
      CmdSampleBx: hits = across(x, grid_cells[0]) * in_span(y, grid_cells[1])
                          * in_span(z, grid_cells[2]);
      CmdSampleBy: hits = in_span(x, grid_cells[0]) * across(y, grid_cells[1])
                          * in_span(z, grid_cells[2]);
      default:     hits = in_span(x, grid_cells[0]) * in_span(y, grid_cells[1])
                          * across(z, grid_cells[2]);
    endcase
    return (c <= CmdSampleEz) ? hits : hits << 1;
  endfunction

  // floor(coef * value^2 * q / 2^34), Q48.16
  function automatic logic [63:0] weighted_energy(input logic [31:0] v, input logic [31:0] coef,
                                                  input logic [3:0] q);
    logic [32:0]  mag;
    logic [63:0]  sq;
    logic [127:0] prod;
    mag  = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    sq   = 64'(mag) * 64'(mag);
    prod = 128'(sq) * 128'(coef) * 128'(q);
    return 64'(prod >> 34);
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // floor(sum * scale / 2^16), saturating
  function automatic logic [63:0] scaled_total(input logic [63:0] sum, input logic [31:0] s);
    logic [127:0] p;
    p = (128'(sum) * 128'(s)) >> 16;
    return (p[127:64] != '0) ? '1 : p[63:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    energy_set_t got;
    energy_set_t want;
    logic [3:0]  q;
    int unsigned comp;
    if (!rst_ni) begin
      foreach (energy_sums[i]) energy_sums[i] = '0;
      foreach (grid_cells[i]) grid_cells[i] = CellW'(1);
      scale_q16 = 32'h0001_0000;
      expected_totals.delete();
      outstanding_o = 0;
    end else begin
      // register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          RegCellsX:      grid_cells[0] = clamp_cells(pwdata_i);
          RegCellsY:      grid_cells[1] = clamp_cells(pwdata_i);
          RegCellsZ:      grid_cells[2] = clamp_cells(pwdata_i);
          RegEnergyScale: scale_q16 = pwdata_i;
          default: ;
        endcase
      end

      // results
      if (out_valid_i && out_ready_i) begin
        got = {energy_bz_i, energy_by_i, energy_bx_i, energy_ez_i, energy_ey_i, energy_ex_i};
        if (expected_totals.size() == 0) begin
          if (mismatches < 10)
            $display("%t: result with none expected: ex=%h ey=%h ez=%h bx=%h by=%h bz=%h",
                     $time, got[0], got[1], got[2], got[3], got[4], got[5]);
          mismatches++;
        end else begin
          want = expected_totals.pop_front();
          for (int c = 0; c < NumComp; c++) begin
            if (got[c] !== want[c]) begin
              if (mismatches < 10)
                $display("%t: energy_%s expected %h, got %h",
                         $time, comp_name[c], want[c], got[c]);
              mismatches++;
            end
          end
        end
      end

      // requests
      if (in_valid_i && in_ready_i) begin
        if (cmd_i <= CmdSampleBz) begin
          comp = cmd_i;
          q = stencil_quarters(cmd_i, pos_x_i, pos_y_i, pos_z_i);
          if (q != '0)
            energy_sums[comp] = sat_sum(energy_sums[comp],
                weighted_energy(value_i, coef_mem[comp * MaterialCount + material_i], q));
        end else if (cmd_i <= CmdCoefBz) begin
          coef_mem[(cmd_i - CmdCoefEx) * MaterialCount + material_i] = value_i;
        end else if (cmd_i == CmdEmit) begin
          for (int c = 0; c < NumComp; c++) begin
            want[c] = scaled_total(energy_sums[c], scale_q16);
            energy_sums[c] = '0;
          end
          expected_totals.push_back(want);
        end
      end
      outstanding_o = expected_totals.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the Yee-grid energy accumulator: stimulus, register setup and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import yge_pkg::*;

  localparam time         ClkPeriod     = 12ns;
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned ItemsPerPhase = 110;
  // long enough for a sample or an emit in flight to finish; this covers both
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned TimeoutCycles = 400_000;
  // commands the block accepts and ignores
  localparam logic [3:0]  CmdNopFirst   = 4'd13;
  localparam logic [3:0]  CmdNopLast    = 4'd15;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [3:0]       cmd       = CmdEmit;
  logic [31:0]      value     = '0;
  logic [7:0]       material  = '0;
  logic [CellW-1:0] pos_x     = '0;
  logic [CellW-1:0] pos_y     = '0;
  logic [CellW-1:0] pos_z     = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [63:0]      energy_ex, energy_ey, energy_ez, energy_bx, energy_by, energy_bz;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [ApbAw-1:0] paddr     = '0;
  logic [31:0]      pwdata    = '0;
  logic [31:0]      prdata;
  logic             pready;

  int               fails;
  int               outstanding;

  // Generator-side view: which coefficient entries hold a value, and the
  // cell counts as the block stores them (used to aim positions at the grid).
  bit               coef_loaded [NumComp][MaterialCount];
  logic [CellW-1:0] grid_n [3] = '{default: CellW'(1)};

  // Idle rates in percent per cycle, set per phase.
  int unsigned      tx_idle_pct  = 0;
  int unsigned      rx_stall_pct = 0;
  // One-shot request for a long receiver hold-off.
  bit               hold_start   = 1'b0;

  yee_grid_field_energy_accumulator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .value_i     (value),
    .material_i  (material),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pos_z_i     (pos_z),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .energy_ex_o (energy_ex),
    .energy_ey_o (energy_ey),
    .energy_ez_o (energy_ez),
    .energy_bx_o (energy_bx),
    .energy_by_o (energy_by),
    .energy_bz_o (energy_bz),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  yge_energy_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .cmd_i            (cmd),
    .value_i          (value),
    .material_i       (material),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .pos_z_i          (pos_z),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .energy_ex_i      (energy_ex),
    .energy_ey_i      (energy_ey),
    .energy_ez_i      (energy_ez),
    .energy_bx_i      (energy_bx),
    .energy_by_i      (energy_by),
    .energy_bz_i      (energy_bz),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (fails),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("end of test: mismatches");
    $finish;
  end

  // Result side. A pending hold-off wins over the random stall rate; the
  // hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_left  = HoldCycles;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  function automatic logic [CellW-1:0] clamp_cells(input logic [31:0] v);
    return (v[CellW-1:0] > GridMax) ? CellW'(GridMax) : v[CellW-1:0];
  endfunction

  // Mostly around the interior plus one ghost layer; sometimes anywhere.
  function automatic logic [CellW-1:0] pick_pos(input logic [CellW-1:0] n);
    if ($urandom_range(0, 99) < 15) return CellW'($urandom_range(0, 2047));
    return CellW'($urandom_range(0, n + 1));
  endfunction

  // Signed Q16.16 sample: extremes, small magnitudes of either sign, or raw bits.
  function automatic logic [31:0] pick_sample();
    logic [31:0] mag;
    mag = $urandom_range(0, 32'h0010_0000);
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3, 4, 5: return $urandom_range(0, 1) ? -mag : mag;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFFF;
      1, 2, 3: return $urandom_range(0, 32'h0003_FFFF);
      default: return $urandom();
    endcase
  endfunction

  // One request: optional idle cycles, then hold valid until accepted.
  task automatic push_request(input logic [3:0] c, input logic [31:0] v, input logic [7:0] m,
                              input logic [CellW-1:0] x, input logic [CellW-1:0] y,
                              input logic [CellW-1:0] z);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    material <= m;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    do @(posedge clk); while (!in_ready);
    if (c >= CmdCoefEx && c <= CmdCoefBz) coef_loaded[c - CmdCoefEx][m] = 1'b1;
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx != RegEnergyScale) grid_n[idx - RegCellsX] = clamp_cells(data);
  endtask

  task automatic setup_grid(input logic [31:0] nx, input logic [31:0] ny, input logic [31:0] nz,
                            input logic [31:0] scale);
    write_reg(RegCellsX, nx);
    write_reg(RegCellsY, ny);
    write_reg(RegCellsZ, nz);
    write_reg(RegEnergyScale, scale);
  endtask

  // Drop valid, wait for every emitted total, then let in-flight samples finish.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Random mix: mostly samples (coefficient loaded first when needed), then
  // coefficient writes, emits and ignored commands.
  task automatic random_request();
    int unsigned roll;
    int unsigned comp;
    logic [7:0]  mat;
    roll = $urandom_range(0, 99);
    comp = $urandom_range(0, NumComp - 1);
    mat  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    if (roll < 70) begin
      if (!coef_loaded[comp][mat])
        push_request(CmdCoefEx + 4'(comp), pick_coef(), mat,
                     CellW'($urandom()), CellW'($urandom()), CellW'($urandom()));
      push_request(CmdSampleEx + 4'(comp), pick_sample(), mat,
                   pick_pos(grid_n[0]), pick_pos(grid_n[1]), pick_pos(grid_n[2]));
    end else if (roll < 88) begin
      push_request(CmdCoefEx + 4'(comp), pick_coef(), mat,
                   CellW'($urandom()), CellW'($urandom()), CellW'($urandom()));
    end else if (roll < 95) begin
      push_request(CmdEmit, $urandom(), mat,
                   CellW'($urandom()), CellW'($urandom()), CellW'($urandom()));
    end else begin
      push_request(4'($urandom_range(CmdNopFirst, CmdNopLast)), $urandom(), mat,
                   CellW'($urandom()), CellW'($urandom()), CellW'($urandom()));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed: 2x2x2 grid so every spreading axis can score two hits ----
    setup_grid(2, 2, 2, 32'h0001_0000);
    // one coefficient per component, extremes on ex/bx, materials 0, 128 and 255
    push_request(CmdCoefEx,          32'hFFFF_FFFF, 8'd0,   '0, '0, '0);
    push_request(CmdCoefEx + 4'd1,   32'h0001_8000, 8'd255, '0, '0, '0);
    push_request(CmdCoefEx + 4'd2,   32'h0001_0000, 8'd0,   '0, '0, '0);
    push_request(CmdCoefEx + 4'd3,   32'hFFFF_FFFF, 8'd0,   '0, '0, '0);
    push_request(CmdCoefEx + 4'd4,   32'h0000_0001, 8'd128, '0, '0, '0);
    push_request(CmdCoefBz,          32'h0000_0000, 8'd0,   '0, '0, '0);
    // largest magnitude, full weight: ex sum saturates after a few of these
    repeat (5) push_request(CmdSampleEx, 32'h8000_0000, 8'd0, 11'd1, 11'd2, 11'd2);
    push_request(CmdSampleBx, 32'h7FFF_FFFF, 8'd0,   11'd2, 11'd1, 11'd1);
    push_request(CmdSampleEy, 32'h0000_0000, 8'd255, 11'd2, 11'd1, 11'd2);
    // outside the stencil: lower ghost corner and far coordinates add nothing
    push_request(CmdSampleEz, 32'hFFFF_FFFF, 8'd0,   11'd0, 11'd0, 11'd0);
    // upper ghost layer still feeds the last interior voxel
    push_request(CmdSampleBy, 32'h0001_0000, 8'd128, 11'd1, 11'd3, 11'd1);
    push_request(CmdSampleBz, 32'hFFFF_0000, 8'd0,   11'd1, 11'd1, 11'd2047);
    for (int c = CmdNopFirst; c <= CmdNopLast; c++)
      push_request(4'(c), $urandom(), 8'hFF, 11'h7FF, 11'h7FF, 11'h7FF);
    push_request(CmdEmit, '0, '0, '0, '0, '0);
    // second emit right away: sums were cleared
    push_request(CmdEmit, '0, '0, '0, '0, '0);
    settle();

    // ---- random phases, each with its own grid, scale and idle pattern ----
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       setup_grid(3, 4, 2, 32'h0001_0000);
        1:       setup_grid(1, 1, 1, 32'h0000_0000);
        2:       setup_grid(GridMax, GridMax, GridMax, 32'hFFFF_FFFF);
        3:       setup_grid(2047, 1500, 1025, 32'h0000_8000);   // stored as the max
        4:       setup_grid(0, 5, 5, $urandom());               // no interior along x
        5:       setup_grid(32'hFFFF_F801, 2, 32'h0000_0800, 32'h0001_0000); // upper bits dropped
        default: setup_grid($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                            ($urandom_range(0, 1) != 0) ? $urandom() : 32'h0001_0000);
      endcase
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 82; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      if (p == 0) begin
        // receiver goes quiet while emits pile up behind the output register
        hold_start = 1'b1;
        repeat (3) push_request(CmdEmit, '0, '0, '0, '0, '0);
      end
      repeat (ItemsPerPhase) random_request();
      push_request(CmdEmit, $urandom(), '0, '0, '0, '0);
      settle();
    end

    if (fails == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
